>>> rtl/core/geometry_command_fifo_unit_defines.svh
// ----------------------------------------------------------------------------
// geometry command fifo assertion macros
// shared assertion forms for the rtl core
// ----------------------------------------------------------------------------
`ifndef GEOMETRY_COMMAND_FIFO_UNIT_DEFINES_SVH
`define GEOMETRY_COMMAND_FIFO_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define GCF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// implication checked at every clock edge out of reset
`define GCF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gcf_pkg.sv
// ----------------------------------------------------------------------------
// gcf_pkg
// types, sizes and the parameter count table of the geometry command fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcf_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PIPE_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PIPE_AW    = $clog2(PIPE_DEPTH);
    localparam int PIPE_CW    = $clog2(PIPE_DEPTH + 1);
    localparam int HALF_LEVEL = FIFO_DEPTH / 2;
    localparam int NUM_PORTS  = 128;
    localparam int PORT_AW    = 7;
    localparam int LEVEL_W    = 9;
    localparam int ENTRY_W    = 40;

    typedef enum logic [1:0] {
        ACT_PACKED = 2'd0,
        ACT_DIRECT = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        IRQ_OFF   = 2'd0,
        IRQ_HALF  = 2'd1,
        IRQ_EMPTY = 2'd2,
        IRQ_RSVD  = 2'd3
    } t_irq_mode;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] byte_lane;
        logic [7:0] data_byte;
        logic [6:0] command_port;
    } t_in_item;

    typedef struct packed {
        logic        executed_valid;
        logic [7:0]  executed_command;
        logic [31:0] executed_param;
        logic        irq;
        logic [31:0] status_word;
        logic [8:0]  fifo_level;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [31:0] par;
    } t_entry;

    // bit 6 marks an existing direct port, bits 5:0 the parameter count
    function automatic logic [6:0] rom_lookup(input logic [6:0] id);
        logic [6:0] r;
        case (id)
            7'h10: r = {1'b1, 6'd1};
            7'h11: r = {1'b1, 6'd0};
            7'h12: r = {1'b1, 6'd1};
            7'h13: r = {1'b1, 6'd1};
            7'h14: r = {1'b1, 6'd1};
            7'h15: r = {1'b1, 6'd0};
            7'h16: r = {1'b1, 6'd16};
            7'h17: r = {1'b1, 6'd12};
            7'h18: r = {1'b1, 6'd16};
            7'h19: r = {1'b1, 6'd12};
            7'h1A: r = {1'b1, 6'd9};
            7'h1B: r = {1'b1, 6'd3};
            7'h1C: r = {1'b1, 6'd3};
            7'h20: r = {1'b1, 6'd1};
            7'h21: r = {1'b1, 6'd1};
            7'h22: r = {1'b1, 6'd1};
            7'h23: r = {1'b1, 6'd2};
            7'h24: r = {1'b1, 6'd1};
            7'h25: r = {1'b1, 6'd1};
            7'h26: r = {1'b1, 6'd1};
            7'h27: r = {1'b1, 6'd1};
            7'h28: r = {1'b1, 6'd1};
            7'h29: r = {1'b1, 6'd1};
            7'h2A: r = {1'b1, 6'd1};
            7'h2B: r = {1'b1, 6'd1};
            7'h30: r = {1'b1, 6'd1};
            7'h31: r = {1'b1, 6'd1};
            7'h32: r = {1'b1, 6'd1};
            7'h33: r = {1'b1, 6'd1};
            7'h34: r = {1'b1, 6'd32};
            7'h40: r = {1'b1, 6'd1};
            7'h41: r = {1'b1, 6'd0};
            7'h50: r = {1'b1, 6'd1};
            7'h60: r = {1'b1, 6'd1};
            7'h70: r = {1'b1, 6'd3};
            7'h71: r = {1'b1, 6'd2};
            7'h72: r = {1'b1, 6'd1};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] merge_lane(input logic [31:0] word,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/geometry_command_fifo_unit.sv
// ----------------------------------------------------------------------------
// geometry_command_fifo_unit
// command queue front end: packed and direct ports, fifo, pipe and status
// ----------------------------------------------------------------------------
// One beat is taken at a time and gives one result beat. A status write goes
// straight to the result. A direct port write does a read-modify-write of the
// port latch memory; an unknown port goes straight to the result. A packed
// write to byte lane 3 drains queued commands one at a time, as the fifo
// memory has a single port. An execute tick does one fifo memory read per
// refill entry and then updates the status. The output register lets the
// next beat start while a result waits. Port latches are cleared by valid
// bits at reset, so no clearing pass is needed.
`timescale 1ns / 1ps

`include "geometry_command_fifo_unit_defines.svh"

module geometry_command_fifo_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gcf_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gcf_pkg::t_out_item   o_out_item
);
    import gcf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_DRD,
        S_TREF,
        S_TSTAT,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic [31:0]        r_latch, n_latch;
    logic [31:0]        r_pend, n_pend;
    logic [5:0]         r_pcnt, n_pcnt;
    logic [NUM_PORTS-1:0] r_dvalid, n_dvalid;
    logic [FIFO_AW-1:0] r_fhead, n_fhead;
    logic [FIFO_CW-1:0] r_fcount, n_fcount;
    logic [PIPE_AW-1:0] r_phead, n_phead;
    logic [PIPE_CW-1:0] r_pcount, n_pcount;
    logic [1:0]         r_mode, n_mode;
    logic               r_half, n_half;
    logic               r_empty, n_empty;
    logic               r_busy, n_busy;
    logic [1:0]         r_refill, n_refill;
    logic               r_xvalid, n_xvalid;
    logic [7:0]         r_xcmd, n_xcmd;
    logic [31:0]        r_xpar, n_xpar;
    logic               r_irq, n_irq;
    logic               r_out_valid;
    t_out_item          r_out;
    t_entry             r_pipe [PIPE_DEPTH];

    // memory ports
    logic               f_we;
    logic [FIFO_AW-1:0] f_addr;
    t_entry             f_wdata;
    logic [ENTRY_W-1:0] f_rdata;
    logic               d_we;
    logic [PORT_AW-1:0] d_addr;
    logic [31:0]        d_rdata;

    // helper terms
    logic               e_req;
    t_entry             e_ent;
    logic               p_we;
    t_entry             p_wdata;
    logic [PIPE_AW-1:0] p_slot;
    logic [PIPE_CW:0]   p_sum;
    logic [FIFO_AW-1:0] f_slot;
    logic [FIFO_CW:0]   f_sum;
    logic [PIPE_AW-1:0] phead_inc;
    logic [FIFO_AW-1:0] fhead_inc;
    logic [PIPE_CW-1:0] tk_pcount;
    logic [1:0]         tk_refill;
    logic [6:0]         in_rom;
    logic [6:0]         pend_rom;
    logic [5:0]         pend_cnt;
    logic [31:0]        pk_merged;
    logic [31:0]        d_merged;
    logic               load_out;
    logic [31:0]        status_now;

    gcf_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_addr  (f_addr),
        .i_wdata (f_wdata),
        .o_rdata (f_rdata)
    );

    gcf_ram #(.WIDTH(32), .DEPTH(NUM_PORTS)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_addr  (d_addr),
        .i_wdata (d_merged),
        .o_rdata (d_rdata)
    );

    assign p_sum  = (PIPE_CW+1)'(r_phead) + (PIPE_CW+1)'(r_pcount);
    assign p_slot = (p_sum >= (PIPE_CW+1)'(PIPE_DEPTH))
                  ? PIPE_AW'(p_sum - (PIPE_CW+1)'(PIPE_DEPTH)) : PIPE_AW'(p_sum);
    assign f_sum  = (FIFO_CW+1)'(r_fhead) + (FIFO_CW+1)'(r_fcount);
    assign f_slot = (f_sum >= (FIFO_CW+1)'(FIFO_DEPTH))
                  ? FIFO_AW'(f_sum - (FIFO_CW+1)'(FIFO_DEPTH)) : FIFO_AW'(f_sum);
    assign phead_inc = (r_phead == PIPE_AW'(PIPE_DEPTH - 1)) ? '0 : r_phead + 1'b1;
    assign fhead_inc = (r_fhead == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_fhead + 1'b1;

    assign tk_pcount = (r_pcount != '0) ? r_pcount - 1'b1 : r_pcount;
    assign tk_refill = (tk_pcount >= PIPE_CW'(PIPE_DEPTH - 1)) ? 2'd0
                     : (r_fcount > FIFO_CW'(2)) ? 2'd2 : 2'(r_fcount);

    assign in_rom    = rom_lookup(i_in_item.command_port);
    // command ids of 128 and up have no parameters
    assign pend_rom  = r_pend[7] ? 7'd0 : rom_lookup(r_pend[6:0]);
    assign pend_cnt  = pend_rom[5:0];
    assign pk_merged = merge_lane(r_latch, i_in_item.byte_lane, i_in_item.data_byte);
    assign d_merged  = merge_lane(r_dvalid[r_item.command_port] ? d_rdata : 32'd0,
                                  r_item.byte_lane, r_item.data_byte);

    assign status_now = {r_mode, 2'b00, r_busy, r_empty, r_half,
                         LEVEL_W'(r_fcount), 16'h0000};
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_latch  = r_latch;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_dvalid = r_dvalid;
        n_fhead  = r_fhead;
        n_fcount = r_fcount;
        n_phead  = r_phead;
        n_pcount = r_pcount;
        n_mode   = r_mode;
        n_half   = r_half;
        n_empty  = r_empty;
        n_busy   = r_busy;
        n_refill = r_refill;
        n_xvalid = r_xvalid;
        n_xcmd   = r_xcmd;
        n_xpar   = r_xpar;
        n_irq    = r_irq;
        e_req    = 1'b0;
        e_ent    = '0;
        f_we     = 1'b0;
        f_addr   = r_fhead;
        f_wdata  = e_ent;
        d_we     = 1'b0;
        d_addr   = r_item.command_port;
        p_we     = 1'b0;
        p_wdata  = e_ent;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_xvalid = 1'b0;
                    n_xcmd   = 8'd0;
                    n_xpar   = 32'd0;
                    n_irq    = 1'b0;
                    n_state  = S_DONE;
                    case (i_in_item.action)
                        ACT_PACKED: begin
                            n_latch = pk_merged;
                            if (i_in_item.byte_lane == 2'd3) begin
                                n_state = S_DRAIN;
                                if (r_pend == 32'd0) begin
                                    n_pend = pk_merged;
                                end else begin
                                    e_req  = 1'b1;
                                    e_ent  = '{cmd: r_pend[7:0], par: pk_merged};
                                    n_pcnt = r_pcnt + 6'd1;
                                    if (n_pcnt == pend_cnt) begin
                                        n_pend = r_pend >> 8;
                                        n_pcnt = 6'd0;
                                    end
                                end
                            end
                        end
                        ACT_DIRECT: begin
                            // unknown ports are ignored
                            if (in_rom[6]) begin
                                d_addr  = i_in_item.command_port;
                                n_state = S_DRD;
                            end
                        end
                        ACT_STATUS: begin
                            if (i_in_item.byte_lane == 2'd3) begin
                                n_mode = i_in_item.data_byte[7:6];
                            end
                        end
                        ACT_TICK: begin
                            if (r_pcount != '0) begin
                                n_xvalid = 1'b1;
                                n_xcmd   = r_pipe[r_phead].cmd;
                                n_xpar   = r_pipe[r_phead].par;
                                n_phead  = phead_inc;
                            end
                            n_pcount = tk_pcount;
                            n_refill = tk_refill;
                            n_state  = (tk_refill != 2'd0) ? S_TREF : S_TSTAT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                // commands without parameters go out one per cycle
                if (r_pend != 32'd0 && pend_cnt == 6'd0) begin
                    e_req  = 1'b1;
                    e_ent  = '{cmd: r_pend[7:0], par: 32'd0};
                    n_pend = r_pend >> 8;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DRD: begin
                d_we = 1'b1;
                n_dvalid[r_item.command_port] = 1'b1;
                if (r_item.byte_lane == 2'd3) begin
                    e_req = 1'b1;
                    e_ent = '{cmd: {1'b0, r_item.command_port}, par: d_merged};
                end
                n_state = S_DONE;
            end
            S_TREF: begin
                p_we     = 1'b1;
                p_wdata  = t_entry'(f_rdata);
                n_pcount = r_pcount + 1'b1;
                n_fhead  = fhead_inc;
                n_fcount = r_fcount - 1'b1;
                n_refill = r_refill - 2'd1;
                f_addr   = fhead_inc;
                n_state  = (r_refill == 2'd2) ? S_TREF : S_TSTAT;
            end
            S_TSTAT: begin
                n_half  = r_half | (r_fcount < FIFO_CW'(HALF_LEVEL));
                n_empty = r_empty | (r_fcount == '0);
                n_busy  = r_busy & (r_pcount != '0);
                n_irq   = (r_mode == IRQ_HALF && n_half) ||
                          (r_mode == IRQ_EMPTY && n_empty);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (e_req) begin
            if (r_fcount == '0 && r_pcount < PIPE_CW'(PIPE_DEPTH)) begin
                p_we     = 1'b1;
                p_wdata  = e_ent;
                n_pcount = r_pcount + 1'b1;
                n_busy   = 1'b1;
            end else if (r_fcount < FIFO_CW'(FIFO_DEPTH)) begin
                f_we     = 1'b1;
                f_addr   = f_slot;
                f_wdata  = e_ent;
                n_fcount = r_fcount + 1'b1;
                if (n_fcount >= FIFO_CW'(HALF_LEVEL)) begin
                    n_half = 1'b0;
                end
                n_empty  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_latch     <= '0;
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_dvalid    <= '0;
            r_fhead     <= '0;
            r_fcount    <= '0;
            r_phead     <= '0;
            r_pcount    <= '0;
            r_mode      <= '0;
            r_half      <= 1'b1;
            r_empty     <= 1'b1;
            r_busy      <= 1'b0;
            r_refill    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_latch  <= n_latch;
            r_pend   <= n_pend;
            r_pcnt   <= n_pcnt;
            r_dvalid <= n_dvalid;
            r_fhead  <= n_fhead;
            r_fcount <= n_fcount;
            r_phead  <= n_phead;
            r_pcount <= n_pcount;
            r_mode   <= n_mode;
            r_half   <= n_half;
            r_empty  <= n_empty;
            r_busy   <= n_busy;
            r_refill <= n_refill;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_xvalid <= n_xvalid;
        r_xcmd   <= n_xcmd;
        r_xpar   <= n_xpar;
        r_irq    <= n_irq;
        if (p_we) begin
            r_pipe[p_slot] <= p_wdata;
        end
        if (load_out) begin
            r_out <= '{executed_valid:   r_xvalid,
                       executed_command: r_xcmd,
                       executed_param:   r_xpar,
                       irq:              r_irq,
                       status_word:      status_now,
                       fifo_level:       LEVEL_W'(r_fcount)};
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `GCF_ASSERT_ALWAYS(a_fifo_bound, r_fcount <= FIFO_CW'(FIFO_DEPTH), "fifo count overrun")
    `GCF_ASSERT_ALWAYS(a_pipe_bound, r_pcount <= PIPE_CW'(PIPE_DEPTH), "pipe count overrun")
    `GCF_ASSERT_IMPL(a_empty_flag, r_empty, r_fcount == '0, "empty bit with fifo entries")
    `GCF_ASSERT_IMPL(a_no_mem_clash, f_we, r_state == S_IDLE || r_state == S_DRAIN ||
        r_state == S_DRD, "fifo write during refill")

endmodule

>>> rtl/core/gcf_ram.sv
// ----------------------------------------------------------------------------
// gcf_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
